@@ sv/bfn_pkg.sv @@
// Shared constants, types and helpers for the FNV-1a Bloom filter.
`timescale 1ns / 1ps

package bfn_pkg;

    localparam int MAX_BYTES    = 4096;
    localparam int MAX_PROBES   = 16;
    localparam int ADDR_W       = $clog2(MAX_BYTES);
    localparam int BIT_W        = $clog2(MAX_BYTES * 8);
    localparam int NBITS_W      = BIT_W + 1;
    localparam int PROBE_W      = $clog2(MAX_PROBES + 1);
    localparam int CFG_BYTES_W  = 13;
    localparam int CFG_PROBES_W = 5;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 16;
    localparam int HASH_W       = 64;
    localparam int MOD_DIGITS   = 4;
    localparam int MOD_STEPS    = HASH_W / MOD_DIGITS;
    localparam int MOD_CNT_W    = $clog2(MOD_STEPS);

    localparam logic [HASH_W-1:0] FNV_BASIS  = 64'hCBF29CE484222325;
    // FNV prime is 2^40 + 0x1B3
    localparam int                FNV_SHIFT  = 40;
    localparam logic [8:0]        FNV_LOW    = 9'h1B3;
    localparam logic [HASH_W-1:0] PROBE_STEP = 64'h9E3779B97F4A7C15;

    typedef enum logic {
        ACT_ADD   = 1'b0,
        ACT_CHECK = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_IN_USE = 8'd0,
        CFG_PROBE_COUNT  = 8'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_TEST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_cmd;

    // One FNV-1a step: xor the byte, multiply by the prime mod 2^64.
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] x;
        logic [HASH_W-1:0] lo;
        x  = h ^ {{(HASH_W-8){1'b0}}, b};
        lo = HASH_W'(x * {{(HASH_W-9){1'b0}}, FNV_LOW});
        return (x << FNV_SHIFT) + lo;
    endfunction

endpackage

@@ sv/bfn_hash.sv @@
// Running FNV-1a hash register, folded one key byte per word.
`timescale 1ns / 1ps

module bfn_hash (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [7:0]                   i_byte,
    input  logic                         i_byte_valid,
    input  logic                         i_last,
    output logic [bfn_pkg::HASH_W-1:0]   o_fold
);

    logic [bfn_pkg::HASH_W-1:0] r_hash;
    logic [bfn_pkg::HASH_W-1:0] n_hash;

    assign o_fold = i_byte_valid ? bfn_pkg::fnv_fold(r_hash, i_byte) : r_hash;

    always_comb begin
        n_hash = r_hash;
        if (i_accept) begin
            // restart at the basis once the key ends
            n_hash = i_last ? bfn_pkg::FNV_BASIS : o_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= bfn_pkg::FNV_BASIS;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

@@ sv/bfn_mod.sv @@
// Iterative 64-bit modulo unit, four dividend bits per cycle.
`timescale 1ns / 1ps

module bfn_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bfn_pkg::HASH_W-1:0]    i_dividend,
    input  logic [bfn_pkg::NBITS_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [bfn_pkg::BIT_W-1:0]     o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [bfn_pkg::MOD_CNT_W-1:0] r_cnt;
    logic [bfn_pkg::HASH_W-1:0]    r_div;
    logic [bfn_pkg::NBITS_W-1:0]   r_divisor;
    logic [bfn_pkg::BIT_W-1:0]     r_rem;
    logic [bfn_pkg::HASH_W-1:0]    n_div;
    logic [bfn_pkg::BIT_W-1:0]     n_rem;

    // restoring steps: remainder stays below the divisor
    always_comb begin
        logic [bfn_pkg::NBITS_W-1:0] v_t;
        n_div = r_div;
        n_rem = r_rem;
        for (int k = 0; k < bfn_pkg::MOD_DIGITS; k++) begin
            v_t   = {n_rem, n_div[bfn_pkg::HASH_W-1]};
            n_div = {n_div[bfn_pkg::HASH_W-2:0], 1'b0};
            if (v_t >= r_divisor) begin
                v_t = v_t - r_divisor;
            end
            n_rem = v_t[bfn_pkg::BIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == bfn_pkg::MOD_CNT_W'(bfn_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div     <= i_dividend;
            r_divisor <= i_divisor;
            r_rem     <= '0;
        end else if (r_busy) begin
            r_div <= n_div;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ sv/bfn_store.sv @@
// Filter bit store: one byte per entry, registered read.
`timescale 1ns / 1ps

module bfn_store (
    input  logic                 i_clk,
    input  bfn_pkg::t_store_cmd  i_cmd,
    output logic [7:0]           o_rd_data
);

    logic [7:0] r_mem [bfn_pkg::MAX_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rd_data <= r_mem[i_cmd.raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/bloom_filter_fnv1a_top.sv @@
// Bloom filter with FNV-1a key hashing: control sequencer and ports.
// A key byte word is taken while idle; the next word may follow in the next cycle.
// A key-ending word runs the probes: for each, the modulo unit (four bits per cycle) finds
// the bit index, then the store is read and, for an add, written back with the bit set;
// a check stops at a clear bit, and the result word follows the probes.
// Reset: synchronous, active low; a clearing pass then zeroes all 4096 bytes of the store
// with s_tready low (configuration writes are still taken).
`timescale 1ns / 1ps

module bloom_filter_fnv1a_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bfn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bfn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input words
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] key_byte
    input  logic [1:0]                        i_s_tuser,   // [0] action, [1] byte_valid
    input  logic                              i_s_tlast,   // last_byte
    // result words
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [7:0]                        o_m_tdata,   // [0] present, [7:1] zero
    output logic                              o_m_tuser    // was_check
);

    bfn_pkg::t_state                  r_state;
    bfn_pkg::t_state                  n_state;
    logic [bfn_pkg::ADDR_W-1:0]       r_clr_addr;
    logic [bfn_pkg::CFG_BYTES_W-1:0]  r_cfg_bytes;
    logic [bfn_pkg::CFG_PROBES_W-1:0] r_cfg_probes;
    bfn_pkg::t_action                 r_action;
    logic                             r_present;
    logic [bfn_pkg::PROBE_W-1:0]      r_probe_idx;
    logic [bfn_pkg::HASH_W-1:0]       r_probe_val;
    logic                             r_out_valid;
    logic                             r_out_check;
    logic                             r_out_present;

    logic                             s_accept;
    logic                             m_accept;
    logic [bfn_pkg::HASH_W-1:0]       hash_fold;
    logic [bfn_pkg::CFG_BYTES_W-1:0]  used_bytes;
    logic [bfn_pkg::PROBE_W-1:0]      used_probes;
    logic [bfn_pkg::NBITS_W-1:0]      nbits;
    logic                             mod_start;
    logic [bfn_pkg::HASH_W-1:0]       mod_dividend;
    logic                             mod_done;
    logic [bfn_pkg::BIT_W-1:0]        bit_idx;
    bfn_pkg::t_store_cmd              store_cmd;
    logic [7:0]                       rd_data;
    logic [7:0]                       bit_mask;
    logic                             bit_set;
    logic                             last_probe;
    logic [bfn_pkg::HASH_W-1:0]       next_probe_val;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign m_accept = r_out_valid && i_m_tready;

    // clamp configuration to the supported range
    always_comb begin
        if (r_cfg_bytes == '0) begin
            used_bytes = bfn_pkg::CFG_BYTES_W'(1);
        end else if (r_cfg_bytes > bfn_pkg::CFG_BYTES_W'(bfn_pkg::MAX_BYTES)) begin
            used_bytes = bfn_pkg::CFG_BYTES_W'(bfn_pkg::MAX_BYTES);
        end else begin
            used_bytes = r_cfg_bytes;
        end
        if (r_cfg_probes > bfn_pkg::CFG_PROBES_W'(bfn_pkg::MAX_PROBES)) begin
            used_probes = bfn_pkg::PROBE_W'(bfn_pkg::MAX_PROBES);
        end else begin
            used_probes = bfn_pkg::PROBE_W'(r_cfg_probes);
        end
    end

    assign nbits = bfn_pkg::NBITS_W'({used_bytes, 3'b000});

    assign bit_mask       = 8'(1) << bit_idx[2:0];
    assign bit_set        = (rd_data & bit_mask) != 8'h00;
    assign last_probe     = (r_probe_idx + 1'b1) == used_probes;
    assign next_probe_val = r_probe_val + bfn_pkg::PROBE_STEP;

    bfn_hash u_hash (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (s_accept),
        .i_byte       (i_s_tdata),
        .i_byte_valid (i_s_tuser[1]),
        .i_last       (i_s_tlast),
        .o_fold       (hash_fold)
    );

    bfn_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (nbits),
        .o_done     (mod_done),
        .o_rem      (bit_idx)
    );

    bfn_store u_store (
        .i_clk     (i_clk),
        .i_cmd     (store_cmd),
        .o_rd_data (rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bfn_pkg::ST_CLEAR: begin
                if (r_clr_addr == bfn_pkg::ADDR_W'(bfn_pkg::MAX_BYTES - 1)) begin
                    n_state = bfn_pkg::ST_IDLE;
                end
            end
            bfn_pkg::ST_IDLE: begin
                if (s_accept && i_s_tlast) begin
                    n_state = (used_probes == '0) ? bfn_pkg::ST_DONE : bfn_pkg::ST_MOD;
                end
            end
            bfn_pkg::ST_MOD: begin
                if (mod_done) begin
                    n_state = bfn_pkg::ST_READ;
                end
            end
            bfn_pkg::ST_READ: begin
                n_state = bfn_pkg::ST_TEST;
            end
            bfn_pkg::ST_TEST: begin
                if ((r_action == bfn_pkg::ACT_CHECK && !bit_set) || last_probe) begin
                    n_state = bfn_pkg::ST_DONE;
                end else begin
                    n_state = bfn_pkg::ST_MOD;
                end
            end
            bfn_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = bfn_pkg::ST_IDLE;
                end
            end
            default: n_state = bfn_pkg::ST_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready      = 1'b0;
        mod_start       = 1'b0;
        mod_dividend    = next_probe_val;
        store_cmd       = '0;
        store_cmd.waddr = bit_idx[bfn_pkg::BIT_W-1:3];
        store_cmd.wdata = rd_data | bit_mask;
        store_cmd.raddr = bit_idx[bfn_pkg::BIT_W-1:3];
        unique case (r_state)
            bfn_pkg::ST_CLEAR: begin
                store_cmd.we    = 1'b1;
                store_cmd.waddr = r_clr_addr;
                store_cmd.wdata = 8'h00;
            end
            bfn_pkg::ST_IDLE: begin
                o_s_tready   = 1'b1;
                mod_dividend = hash_fold;
                mod_start    = s_accept && i_s_tlast && (used_probes != '0);
            end
            bfn_pkg::ST_MOD: begin
            end
            bfn_pkg::ST_READ: begin
                store_cmd.re = 1'b1;
            end
            bfn_pkg::ST_TEST: begin
                store_cmd.we = (r_action == bfn_pkg::ACT_ADD);
                mod_start    = !((r_action == bfn_pkg::ACT_CHECK && !bit_set) || last_probe);
            end
            bfn_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bfn_pkg::ST_CLEAR;
            r_clr_addr   <= '0;
            r_cfg_bytes  <= bfn_pkg::CFG_BYTES_W'(bfn_pkg::MAX_BYTES);
            r_cfg_probes <= bfn_pkg::CFG_PROBES_W'(4);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == bfn_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bfn_pkg::CFG_BYTES_IN_USE) begin
                    r_cfg_bytes <= i_cfg_data[bfn_pkg::CFG_BYTES_W-1:0];
                end else if (i_cfg_index == bfn_pkg::CFG_PROBE_COUNT) begin
                    r_cfg_probes <= i_cfg_data[bfn_pkg::CFG_PROBES_W-1:0];
                end
            end
            // hold the result word until taken
            if (r_state == bfn_pkg::ST_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_accept) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bfn_pkg::ST_IDLE && s_accept && i_s_tlast) begin
            r_action    <= bfn_pkg::t_action'(i_s_tuser[0]);
            r_present   <= 1'b1;
            r_probe_idx <= '0;
            r_probe_val <= hash_fold;
        end
        if (r_state == bfn_pkg::ST_TEST) begin
            r_probe_idx <= r_probe_idx + 1'b1;
            r_probe_val <= next_probe_val;
            if (r_action == bfn_pkg::ACT_CHECK && !bit_set) begin
                r_present <= 1'b0;
            end
        end
        if (r_state == bfn_pkg::ST_DONE && (!r_out_valid || i_m_tready)) begin
            r_out_check   <= (r_action == bfn_pkg::ACT_CHECK);
            r_out_present <= (r_action == bfn_pkg::ACT_CHECK) && r_present;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {7'b0000000, r_out_present};
    assign o_m_tuser   = r_out_check;

endmodule

@@ sv/bfn_checker.sv @@
// Port-level checker for the Bloom filter top level, with its bind.
`timescale 1ns / 1ps

module bfn_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic                              i_s_tlast,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [7:0]                        o_m_tdata,
    input  logic                              o_m_tuser
);

    // reset starts the clearing pass: nothing taken, nothing shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("ports active right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // a key-ending word stops intake while the probes run
    a_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> !o_s_tready)
        else $error("input taken during probes");

    // an add never reports present
    a_add_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 8'h00)
        else $error("add result with present set");

    // a new result word appears only out of the probe sequence
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result word appeared while idle");

endmodule

bind bloom_filter_fnv1a_top bfn_checker u_bfn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tlast   (i_s_tlast),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);
